// File: sv/lmm_pkg.sv
// ----------------------------------------------------------------------------
// Lexicon max-match package
// Shared widths, command and status types, and the feature clip function.
// ----------------------------------------------------------------------------
package lmm_pkg;

  localparam int CHAR_W = 21;
  localparam int FEAT_W = 3;
  localparam int CLIP_W = 8;
  localparam logic [CLIP_W-1:0] CLIP_RESET = 8'd7;
  localparam logic [CLIP_W-1:0] FEAT_SAT = 8'd7;

  typedef struct packed {
    logic take_item;
    logic scan_start;
    logic scan_run;
    logic lex_drop;
    logic lex_flag;
    logic lex_commit;
    logic head_commit;
  } lmm_cmd_t;

  typedef struct packed {
    logic is_lex;
    logic is_last;
    logic plen_short;
    logic plen_long;
    logic fill_full;
    logic fill_one;
    logic scan_done;
    logic out_free;
  } lmm_status_t;

  function automatic logic [FEAT_W-1:0] clip_feat(input logic [CLIP_W-1:0] v,
                                                   input logic [CLIP_W-1:0] lim);
    logic [CLIP_W-1:0] r;
    r = v;
    if (r > lim) r = lim;
    if (r > FEAT_SAT) r = FEAT_SAT;
    return r[FEAT_W-1:0];
  endfunction

endpackage

// File: sv/lmm_if.sv
// ----------------------------------------------------------------------------
// Lexicon max-match channels
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lmm_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [20:0] char_code;
  logic        last;
  modport source(output valid, kind, char_code, last, input ready);
  modport sink(input valid, kind, char_code, last, output ready);
endinterface

interface lmm_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] start_feature;
  logic [2:0] middle_feature;
  logic [2:0] end_feature;
  logic       sentence_end;
  logic       lexicon_overflow;
  modport source(output valid, start_feature, middle_feature, end_feature,
                 sentence_end, lexicon_overflow, input ready);
  modport sink(input valid, start_feature, middle_feature, end_feature,
               sentence_end, lexicon_overflow, output ready);
endinterface

interface lmm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: sv/lmm_datapath.sv
// ----------------------------------------------------------------------------
// Lexicon max-match datapath
// Lexicon memory, scan unit, sentence window, accumulators and result register.
// ----------------------------------------------------------------------------
module lmm_datapath
  import lmm_pkg::*;
#(
  parameter int MAX_WORD_LEN = 8,
  parameter int LEX_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  lmm_cmd_t          cmd,
  output lmm_status_t       status,
  input  logic              item_kind,
  input  logic [CHAR_W-1:0] item_char,
  input  logic              item_last,
  input  logic              cfg_we,
  input  logic [CLIP_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [FEAT_W-1:0] out_start,
  output logic [FEAT_W-1:0] out_middle,
  output logic [FEAT_W-1:0] out_end,
  output logic              out_sent_end,
  output logic              out_overflow
);

  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int PW = $clog2(MAX_WORD_LEN + 2);
  localparam int AW = (LEX_ENTRIES > 1) ? $clog2(LEX_ENTRIES) : 1;
  localparam int CW = $clog2(LEX_ENTRIES + 1);

  logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] lex_chars [LEX_ENTRIES];
  logic [LW-1:0]                       lex_lens [LEX_ENTRIES];
  logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] rd_chars;
  logic [LW-1:0]                       rd_len;

  logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] pend;
  logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] win;
  logic [MAX_WORD_LEN-1:0][LW-1:0]     mid_acc;
  logic [MAX_WORD_LEN-1:0][LW-1:0]     end_acc;
  logic [MAX_WORD_LEN-1:0][LW-1:0]     mid_upd;
  logic [MAX_WORD_LEN-1:0][LW-1:0]     end_upd;
  logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] key;

  logic [PW-1:0]     plen;
  logic [LW-1:0]     fill;
  logic [CW-1:0]     count;
  logic [CW-1:0]     addr;
  logic              rv;
  logic              hit;
  logic [LW-1:0]     best;
  logic              flag;
  logic              is_lex;
  logic              is_last;
  logic [CLIP_W-1:0] clip_max;
  logic              row_match;
  logic              rd_en;

  assign key = is_lex ? pend : win;
  assign rd_en = cmd.scan_run && (addr < count);

  always_comb begin
    row_match = 1'b1;
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      if (rd_len > LW'(k) && rd_chars[k] != key[k]) row_match = 1'b0;
    end
  end

  always_comb begin
    for (int m = 0; m < MAX_WORD_LEN; m++) begin
      mid_upd[m] = mid_acc[m];
      end_upd[m] = end_acc[m];
      if (m >= 1 && LW'(m + 1) < best && mid_acc[m] < best - LW'(2)) begin
        mid_upd[m] = best - LW'(2);
      end
      if (LW'(m + 1) == best && end_acc[m] < best - LW'(1)) begin
        end_upd[m] = best - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_chars <= lex_chars[addr[AW-1:0]];
      rd_len   <= lex_lens[addr[AW-1:0]];
    end
    if (cmd.lex_commit && !hit && count < CW'(LEX_ENTRIES)) begin
      lex_chars[count[AW-1:0]] <= pend;
      lex_lens[count[AW-1:0]]  <= LW'(plen);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
        if (!item_kind && plen == PW'(k)) pend[k] <= item_char;
        if (item_kind && fill == LW'(k)) win[k] <= item_char;
      end
    end else if (cmd.head_commit) begin
      for (int k = 0; k < MAX_WORD_LEN - 1; k++) win[k] <= win[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen      <= '0;
      fill      <= '0;
      count     <= '0;
      addr      <= '0;
      rv        <= 1'b0;
      hit       <= 1'b0;
      best      <= LW'(1);
      flag      <= 1'b0;
      is_lex    <= 1'b0;
      is_last   <= 1'b0;
      clip_max  <= CLIP_RESET;
      mid_acc   <= '0;
      end_acc   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) clip_max <= cfg_data;
      if (cmd.take_item) begin
        is_lex  <= !item_kind;
        is_last <= item_last;
        if (!item_kind && plen <= PW'(MAX_WORD_LEN)) plen <= plen + PW'(1);
        if (item_kind && fill < LW'(MAX_WORD_LEN)) fill <= fill + LW'(1);
      end
      if (cmd.lex_drop) plen <= '0;
      if (cmd.lex_flag) begin
        plen <= '0;
        flag <= 1'b1;
      end
      if (cmd.scan_start) begin
        addr <= '0;
        rv   <= 1'b0;
        hit  <= 1'b0;
        best <= LW'(1);
      end else if (cmd.scan_run) begin
        rv <= rd_en;
        if (rd_en) addr <= addr + CW'(1);
        if (rv && row_match) begin
          if (is_lex) begin
            if (PW'(rd_len) == plen) hit <= 1'b1;
          end else if (rd_len <= fill && rd_len > best) begin
            best <= rd_len;
          end
        end
      end
      if (cmd.lex_commit) begin
        plen <= '0;
        if (!hit) begin
          if (count < CW'(LEX_ENTRIES)) count <= count + CW'(1);
          else flag <= 1'b1;
        end
      end
      if (cmd.head_commit) begin
        out_valid    <= 1'b1;
        out_start    <= clip_feat(CLIP_W'(best - LW'(1)), clip_max);
        out_middle   <= clip_feat(CLIP_W'(mid_upd[0]), clip_max);
        out_end      <= clip_feat(CLIP_W'(end_upd[0]), clip_max);
        out_sent_end <= (fill == LW'(1));
        out_overflow <= flag;
        for (int m = 0; m < MAX_WORD_LEN - 1; m++) begin
          mid_acc[m] <= mid_upd[m+1];
          end_acc[m] <= end_upd[m+1];
        end
        mid_acc[MAX_WORD_LEN-1] <= '0;
        end_acc[MAX_WORD_LEN-1] <= '0;
        fill <= fill - LW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.is_lex     = is_lex;
    status.is_last    = is_last;
    status.plen_short = plen < PW'(2);
    status.plen_long  = plen > PW'(MAX_WORD_LEN);
    status.fill_full  = fill == LW'(MAX_WORD_LEN);
    status.fill_one   = fill == LW'(1);
    status.scan_done  = (addr >= count) && !rv;
    status.out_free   = !out_valid || out_ready;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(MAX_WORD_LEN)) else $error("window fill out of range");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LEX_ENTRIES)) else $error("lexicon count out of range");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.head_commit |-> (!out_valid || out_ready))
    else $error("result register overwritten");
  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.head_commit |-> (best <= fill && best >= LW'(1)))
    else $error("match length exceeds window");

endmodule

// File: sv/lmm_ctrl.sv
// ----------------------------------------------------------------------------
// Lexicon max-match controller
// Sequences item intake, lexicon scans, word commits and result emission.
// ----------------------------------------------------------------------------
module lmm_ctrl
  import lmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  lmm_status_t status,
  output lmm_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DISPATCH = 4'b0010,
    S_SCAN     = 4'b0100,
    S_EMIT     = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.take_item = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        if (status.is_lex) begin
          if (status.is_last) begin
            if (status.plen_short) cmd.lex_drop = 1'b1;
            else if (status.plen_long) cmd.lex_flag = 1'b1;
            else begin
              cmd.scan_start = 1'b1;
              state_next = S_SCAN;
            end
          end
        end else if (status.is_last || status.fill_full) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          if (status.is_lex) begin
            cmd.lex_commit = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.head_commit = 1'b1;
          if (status.is_last && !status.fill_one) begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_emit_only_sentence: assert property (@(posedge clk) disable iff (rst)
    cmd.head_commit |-> !status.is_lex) else $error("emit during lexicon load");
  a_commit_only_lex: assert property (@(posedge clk) disable iff (rst)
    cmd.lex_commit |-> status.is_lex) else $error("word commit in sentence mode");
  a_scan_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> state == S_SCAN) else $error("scan not entered");

endmodule

// File: sv/lexicon_max_match_features.sv
// ----------------------------------------------------------------------------
// Lexicon max-match features
// Loads a lexicon and emits longest-match start, middle and end features.
// ----------------------------------------------------------------------------
// A word end scans the stored words, one lexicon memory row per cycle. Once
// the window is full or the sentence ends, the head position is matched by
// such a scan before it reaches the result register, and a sentence end
// emits its remaining positions one by one, each after its own scan. No new
// item is taken until the last is done. Reset (synchronous, active high)
// empties lexicon and window, clears overflow, sets clip to 7.
module lexicon_max_match_features
  import lmm_pkg::*;
#(
  parameter int MAX_WORD_LEN = 8,
  parameter int LEX_ENTRIES = 1024
) (
  input logic          clk,
  input logic          rst,
  lmm_item_if.sink     item,
  lmm_result_if.source result,
  lmm_cfg_if.sink      cfg
);

  lmm_cmd_t    cmd;
  lmm_status_t status;

  assign cfg.ready = 1'b1;

  lmm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  lmm_datapath #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .LEX_ENTRIES  (LEX_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_kind    (item.kind),
    .item_char    (item.char_code),
    .item_last    (item.last),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.data),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_start    (result.start_feature),
    .out_middle   (result.middle_feature),
    .out_end      (result.end_feature),
    .out_sent_end (result.sentence_end),
    .out_overflow (result.lexicon_overflow)
  );

endmodule

// File: sim/lmm_feature_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lexicon max-match feature checker
// Watches the item, configuration and result channels, keeps its own copy of
// the lexicon, sentence window and feature accumulators, works out the
// expected features of every accepted transaction and compares each result.
// ----------------------------------------------------------------------------
module lmm_feature_checker
  import lmm_pkg::*;
#(
  parameter int WORD_MAX = 8,
  parameter int LEX_SIZE = 16
) (
  input  logic  clk,
  input  logic  rst,
  lmm_item_if   item,
  lmm_result_if result,
  lmm_cfg_if    cfg,
  output int    errors,
  output int    pending,
  output int    seen,
  output int    lex_words
);

  typedef struct packed {
    logic [FEAT_W-1:0] start_f;
    logic [FEAT_W-1:0] middle_f;
    logic [FEAT_W-1:0] end_f;
    logic              sent_end;
    logic              overflow;
  } feature_t;

  feature_t               due_q[$];
  logic [CHAR_W-1:0]      lex_chars[LEX_SIZE][WORD_MAX];
  int                     lex_len[LEX_SIZE];
  int                     lex_count;
  logic [CHAR_W-1:0]      word_buf[WORD_MAX];
  int                     word_len;
  logic [CHAR_W-1:0]      window[WORD_MAX];
  int                     fill;
  int                     mid_acc[WORD_MAX];
  int                     end_acc[WORD_MAX];
  logic                   ovf;
  logic [CLIP_W-1:0]      clip_max;

  function automatic logic [FEAT_W-1:0] clipped(input int v);
    int r;
    r = v;
    if (r > clip_max) r = clip_max;
    if (r > 7) r = 7;
    return r[FEAT_W-1:0];
  endfunction

  function automatic bit lex_holds(input logic [CHAR_W-1:0] w[WORD_MAX], input int len);
    bit same;
    for (int e = 0; e < lex_count; e++) begin
      if (lex_len[e] != len) continue;
      same = 1;
      for (int k = 0; k < len; k++) if (lex_chars[e][k] != w[k]) same = 0;
      if (same) return 1;
    end
    return 0;
  endfunction

  task automatic close_word();
    int len;
    len = word_len;
    word_len = 0;
    if (len < 2) return;
    if (len > WORD_MAX) begin
      ovf = 1;
    end else if (!lex_holds(word_buf, len)) begin
      if (lex_count >= LEX_SIZE) begin
        ovf = 1;
      end else begin
        for (int k = 0; k < len; k++) lex_chars[lex_count][k] = word_buf[k];
        lex_len[lex_count] = len;
        lex_count++;
      end
    end
  endtask

  task automatic match_head(input bit is_end);
    int len;
    feature_t f;
    len = fill < WORD_MAX ? fill : WORD_MAX;
    while (len > 1 && !lex_holds(window, len)) len--;
    if (len < 1) len = 1;
    for (int m = 1; m + 1 < len; m++) if (mid_acc[m] < len - 2) mid_acc[m] = len - 2;
    if (end_acc[len-1] < len - 1) end_acc[len-1] = len - 1;
    f.start_f = clipped(len - 1);
    f.middle_f = clipped(mid_acc[0]);
    f.end_f = clipped(end_acc[0]);
    f.sent_end = is_end;
    f.overflow = ovf;
    due_q.push_back(f);
    for (int m = 0; m + 1 < WORD_MAX; m++) begin
      window[m] = window[m+1];
      mid_acc[m] = mid_acc[m+1];
      end_acc[m] = end_acc[m+1];
    end
    window[WORD_MAX-1] = '0;
    mid_acc[WORD_MAX-1] = 0;
    end_acc[WORD_MAX-1] = 0;
    if (fill > 0) fill--;
  endtask

  task automatic absorb(input logic kind, input logic [CHAR_W-1:0] ch, input logic last);
    int n;
    if (kind == 1'b0) begin
      if (word_len < WORD_MAX) word_buf[word_len] = ch;
      if (word_len <= WORD_MAX) word_len++;
      if (last) close_word();
    end else begin
      if (fill < WORD_MAX) begin
        window[fill] = ch;
        fill++;
      end
      if (last) begin
        n = 0;
        while (fill > 0 && n < WORD_MAX) begin
          match_head(fill == 1);
          n++;
        end
        fill = 0;
      end else if (fill >= WORD_MAX) begin
        match_head(1'b0);
      end
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    feature_t w;
    if (rst) begin
      errors = 0;
      seen = 0;
      due_q.delete();
      lex_count = 0;
      word_len = 0;
      fill = 0;
      ovf = 0;
      clip_max = CLIP_RESET;
      for (int m = 0; m < WORD_MAX; m++) begin
        mid_acc[m] = 0;
        end_acc[m] = 0;
        window[m] = '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) clip_max = cfg.data;
      if (item.valid && item.ready) absorb(item.kind, item.char_code, item.last);
      if (result.valid && result.ready) begin
        seen++;
        if (due_q.size() == 0) begin
          report("unexpected result, sentence_end", result.sentence_end, 0);
        end else begin
          w = due_q.pop_front();
          if (result.start_feature !== w.start_f)
            report("start_feature", result.start_feature, w.start_f);
          if (result.middle_feature !== w.middle_f)
            report("middle_feature", result.middle_feature, w.middle_f);
          if (result.end_feature !== w.end_f)
            report("end_feature", result.end_feature, w.end_f);
          if (result.sentence_end !== w.sent_end)
            report("sentence_end", result.sentence_end, w.sent_end);
          if (result.lexicon_overflow !== w.overflow)
            report("lexicon_overflow", result.lexicon_overflow, w.overflow);
        end
      end
    end
    pending = due_q.size();
    lex_words = lex_count;
  end

endmodule

// File: sim/lexicon_max_match_features_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lexicon max-match features testbench
// Loads lexicons and streams sentences with random gaps and result stalls,
// covering short, maximal, too-long, duplicate and table-full words, words
// added mid-sentence and several clip settings; a checker compares results.
// ----------------------------------------------------------------------------
module lexicon_max_match_features_test;
  import lmm_pkg::*;

  localparam int WORD_MAX = 8;
  localparam int LEX_SIZE = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 80;

  logic clk;
  logic rst;
  int   errors, pending, seen, lex_words;
  int   cycles = 0;
  int   sent;
  bit   calm;
  int   hold;
  typedef int chars_t[$];

  lmm_item_if   item();
  lmm_result_if result();
  lmm_cfg_if    cfg();

  lexicon_max_match_features #(.MAX_WORD_LEN(WORD_MAX), .LEX_ENTRIES(LEX_SIZE)) uut (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg)
  );

  lmm_feature_checker #(.WORD_MAX(WORD_MAX), .LEX_SIZE(LEX_SIZE)) checker_i (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg),
    .errors(errors), .pending(pending), .seen(seen), .lex_words(lex_words)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_char();
    if ($urandom_range(0, 4) != 0) return 97 + $urandom_range(0, 3);
    return $urandom_range(0, 1114111);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      hold <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      result.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      hold <= pick_gap();
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  task automatic send(input logic kind, input int ch, input logic last);
    int gap;
    item.valid <= 1'b1;
    item.kind <= kind;
    item.char_code <= ch[CHAR_W-1:0];
    item.last <= last;
    do @(posedge clk); while (!item.ready);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(input logic kind, input chars_t s);
    for (int i = 0; i < s.size(); i++) send(kind, s[i], i == s.size() - 1);
  endtask

  task automatic write_clip(input int v);
    item.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v[CLIP_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int long_max);
    chars_t s;
    int len;
    int goal;
    goal = sent + n;
    while (sent < goal) begin
      s.delete();
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) begin
        len = $urandom_range(0, 5) == 0 ? $urandom_range(1, long_max)
                                         : $urandom_range(2, 4);
        repeat (len) s.push_back(pick_char());
        send_run(1'b0, s);
      end else begin
        len = $urandom_range(0, 6) == 0 ? $urandom_range(9, 14) : $urandom_range(1, 8);
        repeat (len) s.push_back(pick_char());
        send_run(1'b1, s);
      end
    end
    calm = 0;
  endtask

  initial begin
    chars_t w;
    rst = 1'b1;
    sent = 0;
    calm = 0;
    item.valid <= 1'b0;
    item.kind <= 1'b0;
    item.char_code <= '0;
    item.last <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_run(1'b0, '{65, 66});
    send_run(1'b0, '{65, 66, 67, 68});
    send_run(1'b0, '{67, 68, 69, 70, 71, 72, 73, 74});
    send_run(1'b0, '{88});
    send_run(1'b0, '{65, 66});
    send_run(1'b0, '{1114111, 0});
    send_run(1'b1, '{65});
    send_run(1'b1, '{65, 66, 67, 68, 69, 70, 71, 72, 73, 74});
    send_run(1'b1, '{1114111, 0, 65, 66});
    send(1'b1, 90, 1'b0);
    send(1'b1, 90, 1'b0);
    send_run(1'b0, '{90, 90});
    send(1'b1, 90, 1'b1);

    write_clip(0);
    send_run(1'b1, '{67, 68, 69, 70, 71, 72, 73, 74});
    write_clip(255);
    random_phase(10, 8);

    write_clip(3);
    while (lex_words < LEX_SIZE) begin
      w.delete();
      w.push_back($urandom_range(0, 1114111));
      w.push_back($urandom_range(0, 1114111));
      send_run(1'b0, w);
      item.valid <= 1'b0;
      @(posedge clk);
    end
    send_run(1'b0, '{65, 66});
    send_run(1'b1, '{65, 66, 67, 68});
    send_run(1'b0, '{75, 76, 77});
    send_run(1'b0, '{65, 66, 67, 68, 69, 70, 71, 72, 73});
    send_run(1'b1, '{65, 66, 67, 68, 69});

    write_clip(1);
    random_phase(8, 11);
    write_clip($urandom_range(0, 255));
    random_phase(8, 11);

    item.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("%0d transactions sent, %0d results checked, %0d lexicon words stored",
             sent, seen, lex_words);
    $display("clip settings 7, 0, 255, 3, 1 and random; overflow and full table reached");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
